@@ rtl/core/dpt_pkg.sv @@
// Shared types and constants for the deterministic primality test.
// Holds the controller/datapath command and status structs and the base tables.
// No dependencies.
`default_nettype none

package dpt_pkg;

    localparam int unsigned BASE_COUNT = 7;
    localparam int unsigned IDX_BITS   = 3;
    localparam logic [63:0] SMALL_SET_LIMIT = 64'd341550071728321;

    typedef enum logic [1:0] {
        MUL_RX = 2'd0,
        MUL_XX = 2'd1,
        MUL_VV = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     load_n;
        logic     init_split;
        logic     shift_d;
        logic     base_clr;
        logic     base_inc;
        logic     base_load;
        logic     mul_go;
        mul_sel_t mul_sel;
        logic     e_shift;
        logic     round_clr;
        logic     round_inc;
    } dp_cmd_t;

    typedef struct packed {
        logic n_lt2;
        logic n_lt4;
        logic n_even;
        logic d_even;
        logic base_ge_n;
        logic base_last;
        logic e_zero;
        logic e_lsb;
        logic r_one;
        logic r_nm1;
        logic round_end;
        logic mul_done;
    } dp_status_t;

    function automatic logic [63:0] base_value(input logic large_set,
                                               input logic [IDX_BITS-1:0] idx);
        logic [63:0] v;
        v = 64'd0;
        if (large_set)
        begin
            case (idx)
                3'd0:    v = 64'd2;
                3'd1:    v = 64'd325;
                3'd2:    v = 64'd9375;
                3'd3:    v = 64'd28178;
                3'd4:    v = 64'd450775;
                3'd5:    v = 64'd9780504;
                3'd6:    v = 64'd1795265022;
                default: v = 64'd0;
            endcase
        end
        else
        begin
            case (idx)
                3'd0:    v = 64'd2;
                3'd1:    v = 64'd3;
                3'd2:    v = 64'd5;
                3'd3:    v = 64'd7;
                3'd4:    v = 64'd11;
                3'd5:    v = 64'd13;
                3'd6:    v = 64'd17;
                default: v = 64'd0;
            endcase
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/dpt_modmul.sv @@
// Iterative modular multiplier: one double-and-add step per cycle.
// Uses no package items; instantiated by dpt_datapath.
`default_nettype none

module dpt_modmul #(
    parameter int unsigned W = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic [W-1:0] m,
    output logic              done,
    output logic [W-1:0]      result
);

    localparam int unsigned CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  m_reg, m_next;
    logic [W-1:0]  acc_reg, acc_next;

    logic [W:0] dbl, dbl_red, sum, sum_red;

    // Both sums stay below twice the modulus, so one subtract reduces each.
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        sum     = dbl_red + {1'b0, a_reg};
        sum_red = (sum >= {1'b0, m_reg}) ? sum - {1'b0, m_reg} : sum;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            a_next    = a;
            b_next    = b;
            m_next    = m;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = b_reg[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire

@@ rtl/core/dpt_datapath.sv @@
// Datapath of the primality test: operand registers, base table and multiplier.
// Depends on dpt_pkg and dpt_modmul.
`default_nettype none

module dpt_datapath
    import dpt_pkg::*;
#(
    parameter int unsigned W = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [63:0]  candidate,
    input  wire dp_cmd_t      cmd,
    output dp_status_t        status
);

    localparam int unsigned SW = $clog2(W);

    logic [W-1:0]        n_reg, n_next;
    logic [W-1:0]        d_reg, d_next;
    logic [SW-1:0]       s_reg, s_next;
    logic [SW-1:0]       rnd_reg, rnd_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic [W-1:0]        x_reg, x_next;
    logic [W-1:0]        e_reg, e_next;
    logic [W-1:0]        r_reg, r_next;
    mul_sel_t            sel_reg, sel_next;

    logic [63:0]  n_wide;
    logic [63:0]  base;
    logic         large_set;
    logic [W-1:0] mul_a, mul_b, mul_res;
    logic         mul_done;

    assign n_wide    = 64'(n_reg);
    assign large_set = (n_wide >= SMALL_SET_LIMIT);
    assign base      = base_value(large_set, idx_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_RX:
            begin
                mul_a = r_reg;
                mul_b = x_reg;
            end
            MUL_XX:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            MUL_VV:
            begin
                mul_a = r_reg;
                mul_b = r_reg;
            end
            default:
            begin
                mul_a = r_reg;
                mul_b = r_reg;
            end
        endcase
    end

    dpt_modmul #(.W(W)) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_go),
        .a      (mul_a),
        .b      (mul_b),
        .m      (n_reg),
        .done   (mul_done),
        .result (mul_res)
    );

    always_comb
    begin
        n_next   = n_reg;
        d_next   = d_reg;
        s_next   = s_reg;
        rnd_next = rnd_reg;
        idx_next = idx_reg;
        x_next   = x_reg;
        e_next   = e_reg;
        r_next   = r_reg;
        sel_next = sel_reg;
        if (cmd.load_n)
        begin
            n_next = candidate[W-1:0];
        end
        if (cmd.init_split)
        begin
            d_next = n_reg - 1'b1;
            s_next = '0;
        end
        if (cmd.shift_d)
        begin
            d_next = d_reg >> 1;
            s_next = s_reg + 1'b1;
        end
        if (cmd.base_clr)
        begin
            idx_next = '0;
        end
        if (cmd.base_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.base_load)
        begin
            // The base is below n here, so it fits the word.
            x_next = base[W-1:0];
            e_next = d_reg;
            r_next = W'(1);
        end
        if (mul_done)
        begin
            case (sel_reg)
                MUL_RX:  r_next = mul_res;
                MUL_XX:  x_next = mul_res;
                MUL_VV:  r_next = mul_res;
                default: r_next = mul_res;
            endcase
        end
        if (cmd.mul_go)
        begin
            sel_next = cmd.mul_sel;
        end
        if (cmd.e_shift)
        begin
            e_next = e_reg >> 1;
        end
        if (cmd.round_clr)
        begin
            rnd_next = '0;
        end
        if (cmd.round_inc)
        begin
            rnd_next = rnd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        s_reg   <= s_next;
        rnd_reg <= rnd_next;
        idx_reg <= idx_next;
        x_reg   <= x_next;
        e_reg   <= e_next;
        r_reg   <= r_next;
        sel_reg <= sel_next;
    end

    always_comb
    begin
        status.n_lt2     = (n_wide < 64'd2);
        status.n_lt4     = (n_wide < 64'd4);
        status.n_even    = ~n_reg[0];
        status.d_even    = ~d_reg[0];
        status.base_ge_n = (base >= n_wide);
        status.base_last = (idx_reg == IDX_BITS'(BASE_COUNT - 1));
        status.e_zero    = (e_reg == '0);
        status.e_lsb     = e_reg[0];
        status.r_one     = (r_reg == W'(1));
        status.r_nm1     = (r_reg == n_reg - 1'b1);
        status.round_end = (rnd_reg == s_reg);
        status.mul_done  = mul_done;
    end

endmodule

`default_nettype wire

@@ rtl/core/dpt_ctrl.sv @@
// Controller of the primality test: sequences the rounds and holds the result beat.
// Depends on dpt_pkg.
`default_nettype none

module dpt_ctrl
    import dpt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            is_prime,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b000000000001,
        ST_CLASSIFY  = 12'b000000000010,
        ST_SPLIT     = 12'b000000000100,
        ST_BASE      = 12'b000000001000,
        ST_POW       = 12'b000000010000,
        ST_MUL_RX    = 12'b000000100000,
        ST_MUL_XX    = 12'b000001000000,
        ST_WIT_FIRST = 12'b000010000000,
        ST_WIT_LOOP  = 12'b000100000000,
        ST_MUL_VV    = 12'b001000000000,
        ST_NEXT_BASE = 12'b010000000000,
        ST_DONE      = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   verdict_reg, verdict_next;
    logic   out_valid_reg, out_valid_next;
    logic   is_prime_reg, is_prime_next;

    always_comb
    begin
        state_next     = state_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg;
        is_prime_next  = is_prime_reg;
        cmd            = '0;
        cmd.mul_sel    = MUL_RX;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_n = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                if (status.n_lt2)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else if (status.n_lt4)
                begin
                    verdict_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (status.n_even)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.init_split = 1'b1;
                    state_next     = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (status.d_even)
                begin
                    cmd.shift_d = 1'b1;
                end
                else
                begin
                    cmd.base_clr = 1'b1;
                    state_next   = ST_BASE;
                end
            end
            ST_BASE:
            begin
                if (status.base_ge_n)
                begin
                    verdict_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.base_load = 1'b1;
                    state_next    = ST_POW;
                end
            end
            ST_POW:
            begin
                if (status.e_zero)
                begin
                    state_next = ST_WIT_FIRST;
                end
                else if (status.e_lsb)
                begin
                    cmd.mul_go  = 1'b1;
                    cmd.mul_sel = MUL_RX;
                    state_next  = ST_MUL_RX;
                end
                else
                begin
                    cmd.mul_go  = 1'b1;
                    cmd.mul_sel = MUL_XX;
                    state_next  = ST_MUL_XX;
                end
            end
            ST_MUL_RX:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_go  = 1'b1;
                    cmd.mul_sel = MUL_XX;
                    state_next  = ST_MUL_XX;
                end
            end
            ST_MUL_XX:
            begin
                if (status.mul_done)
                begin
                    cmd.e_shift = 1'b1;
                    state_next  = ST_POW;
                end
            end
            ST_WIT_FIRST:
            begin
                cmd.round_clr = 1'b1;
                if (status.r_one)
                begin
                    state_next = ST_NEXT_BASE;
                end
                else
                begin
                    state_next = ST_WIT_LOOP;
                end
            end
            ST_WIT_LOOP:
            begin
                if (status.round_end)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else if (status.r_nm1)
                begin
                    state_next = ST_NEXT_BASE;
                end
                else
                begin
                    cmd.mul_go    = 1'b1;
                    cmd.mul_sel   = MUL_VV;
                    cmd.round_inc = 1'b1;
                    state_next    = ST_MUL_VV;
                end
            end
            ST_MUL_VV:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_WIT_LOOP;
                end
            end
            ST_NEXT_BASE:
            begin
                if (status.base_last)
                begin
                    verdict_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.base_inc = 1'b1;
                    state_next   = ST_BASE;
                end
            end
            ST_DONE:
            begin
                // Wait until the output register is free or being emptied.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = verdict_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg  <= verdict_next;
        is_prime_reg <= is_prime_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

endmodule

`default_nettype wire

@@ rtl/core/deterministic_primality_test_64.sv @@
// Top level of the deterministic Miller-Rabin primality test.
// Depends on dpt_pkg, dpt_ctrl and dpt_datapath.
`default_nettype none

// Takes one candidate beat at a time and returns one is_prime beat. Only the low
// WORD_BITS bits of candidate are tested. The block works on one candidate at a
// time and stalls input until that candidate's verdict has been loaded into the
// output register; the next candidate may be accepted while that verdict waits.
// Latency is set by the single shared modular multiplier, which takes one load
// step and then one double-and-add step per bit for each product. Small and
// even candidates are settled in the classify state. An odd candidate first
// splits n-1 into d * 2^s, then for each base tested runs (popcount(d) +
// bits(d)) + up to s squarings multiplications.

module deterministic_primality_test_64
    import dpt_pkg::*;
#(
    parameter int unsigned WORD_BITS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] candidate,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             is_prime
);

    dp_cmd_t    cmd;
    dp_status_t status;

    dpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime),
        .status    (status),
        .cmd       (cmd)
    );

    dpt_datapath #(.W(WORD_BITS)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .candidate (candidate),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

@@ verif/deterministic_primality_test_64_checker.sv @@
// Scoreboard for the primality test: watches both channels, works out each verdict itself
// and counts mismatches. Needs dpt_pkg for the small-set limit.
`timescale 1ns / 100ps

module deterministic_primality_test_64_checker
    import dpt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [63:0] candidate,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        is_prime,
    output int               verdicts_pending,
    output int               mismatches
);

    bit pending_verdicts[$];

    function automatic logic [63:0] mod_product(input logic [63:0] a, input logic [63:0] b,
                                                input logic [63:0] m);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p % {64'd0, m};
        return p[63:0];
    endfunction

    function automatic logic [63:0] mod_power(input logic [63:0] x, input logic [63:0] e,
                                              input logic [63:0] m);
        logic [63:0] r;
        r = 64'd1;
        while (e != 64'd0)
        begin
            if (e[0])
                r = mod_product(r, x, m);
            x = mod_product(x, x, m);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic bit base_proves_composite(input logic [63:0] a, input logic [63:0] n,
                                                 input logic [63:0] d, input int s);
        logic [63:0] v;
        v = mod_power(a, d, n);
        if (v == 64'd1)
            return 1'b0;
        for (int r = 0; r < s; r++)
        begin
            if (v == n - 64'd1)
                return 1'b0;
            v = mod_product(v, v, n);
        end
        return 1'b1;
    endfunction

    function automatic bit primality_verdict(input logic [63:0] n);
        logic [63:0] d;
        logic [63:0] bases [7];
        int s;
        if (n < 64'd2)
            return 1'b0;
        if (n < 64'd4)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        d = n - 64'd1;
        s = 0;
        while (!d[0])
        begin
            d = d >> 1;
            s++;
        end
        if (n < SMALL_SET_LIMIT)
            bases = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17};
        else
            bases = '{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504,
                      64'd1795265022};
        foreach (bases[i])
        begin
            // A base that reaches n settles the candidate as prime.
            if (n <= bases[i])
                return 1'b1;
            if (base_proves_composite(bases[i], n, d, s))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_verdicts.delete();
            verdicts_pending = 0;
            mismatches = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected is_prime beat: %0b", is_prime);
                end
                else
                begin
                    bit want;
                    want = pending_verdicts.pop_front();
                    if (is_prime !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("is_prime mismatch: expected %0b, got %0b", want,
                                     is_prime);
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_verdicts.push_back(primality_verdict(candidate));
            verdicts_pending = pending_verdicts.size();
        end
    end

endmodule

@@ verif/deterministic_primality_test_64_tb.sv @@
// Testbench top for deterministic_primality_test_64: clock, reset, candidate stimulus and
// receiver stalls. Depends on the block and deterministic_primality_test_64_checker.
`timescale 1ns / 100ps

module deterministic_primality_test_64_tb;

    localparam longint unsigned CYCLE_LIMIT = 64'd40000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] candidate;
    logic        out_valid;
    logic        out_stall;
    logic        is_prime;
    int          verdicts_pending;
    int          mismatches;
    bit          quiet;
    int          stall_left;
    longint unsigned cycles;

    deterministic_primality_test_64 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .candidate (candidate),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime)
    );

    deterministic_primality_test_64_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .candidate        (candidate),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .is_prime         (is_prime),
        .verdicts_pending (verdicts_pending),
        .mismatches       (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver stalls come in bursts of random length.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!quiet && rst_n && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 15);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_candidate(input logic [63:0] value);
        bit stalled;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            candidate <= {$urandom, $urandom};
            repeat ($urandom_range(0, 15)) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        candidate <= value;
        forever
        begin
            #1;
            stalled = in_stall;
            @(posedge clk);
            if (!stalled)
                break;
            @(negedge clk);
        end
    endtask

    function automatic logic [63:0] random_candidate();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       v = v;
            1:       v = v | 64'd1;
            2:       v = v % 64'd1048576;
            3:       v = (v % 64'd341550071728321) | 64'd1;
            4:       v = 64'd341550071728321 + $urandom_range(0, 4000) - 64'd2000;
            default: v = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 400);
        endcase
        return v;
    endfunction

    initial
    begin
        logic [63:0] directed [$];
        rst_n = 1'b0;
        in_valid = 1'b0;
        candidate = 64'd0;
        out_stall = 1'b0;
        quiet = 1'b0;
        stall_left = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Trivial values, bases reaching the candidate, strong pseudoprimes, the set
        // boundary and values near the top of the 64-bit range.
        directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd7, 64'd9, 64'd13,
                     64'd17, 64'd19, 64'd561, 64'd2047, 64'd1373653, 64'd25326001,
                     64'd3215031751, 64'd341550071728321, 64'd341550071728319,
                     64'd341550071728323, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFFE, 64'd18446744073709551557,
                     64'h8000_0000_0000_0001, 64'd4294967291};
        foreach (directed[i])
            send_candidate(directed[i]);

        for (int i = 0; i < 76; i++)
        begin
            if (i == 30)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                wait (verdicts_pending == 0);
            end
            if (i == 65)
                quiet = 1'b1;
            send_candidate(random_candidate());
        end
        @(negedge clk);
        in_valid <= 1'b0;

        wait (verdicts_pending == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && verdicts_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/dpt_pkg.sv
rtl/core/dpt_modmul.sv
rtl/core/dpt_datapath.sv
rtl/core/dpt_ctrl.sv
rtl/core/deterministic_primality_test_64.sv
verif/deterministic_primality_test_64_checker.sv
verif/deterministic_primality_test_64_tb.sv
